/* rtl/bblur_pkg.sv */
package bblur_pkg;

    localparam int CHAN_W       = 8;
    localparam int NUM_CHAN     = 3;
    localparam int PIX_W        = CHAN_W * NUM_CHAN;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST = 13'd768;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    // what the back end does with one queued word
    typedef struct packed
    {
        logic is_pixel;
        logic emit;
        logic blur;
        logic eof;
    } blur_cmd_t;

endpackage

/* rtl/bblur_fifo.sv */
module bblur_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/bblur_front.sv */
module bblur_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int AW         = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bblur_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [0:0]                          in_opcode,
    input  logic [bblur_pkg::PIX_W-1:0]         in_pix,
    input  logic                                q_full,
    output logic                                q_push,
    output bblur_pkg::blur_cmd_t                q_cmd,
    output logic [bblur_pkg::PIX_W-1:0]         q_pix,
    output logic [AW-1:0]                       q_wr_addr,
    output logic [AW-1:0]                       q_addr_a,
    output logic [AW-1:0]                       q_addr_b
);

    import bblur_pkg::*;

    localparam int RING_DEPTH = 2 * MAX_WIDTH + 1;
    localparam int WEW        = $clog2(MAX_WIDTH + 1);
    localparam int HEW        = $clog2(MAX_HEIGHT + 1);
    localparam int COLW       = $clog2(MAX_WIDTH);
    localparam int ROWW       = $clog2(MAX_HEIGHT);
    localparam int PW         = $clog2(MAX_WIDTH + 3);

    logic [WIDTH_REG_W-1:0]  fw_reg;
    logic [HEIGHT_REG_W-1:0] fh_reg;
    logic [COLW-1:0]         in_col_reg, in_col_next;
    logic [ROWW-1:0]         in_row_reg, in_row_next;
    logic [COLW-1:0]         out_col_reg, out_col_next;
    logic [ROWW-1:0]         out_row_reg, out_row_next;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [PW-1:0]           pend_reg, pend_next;

    logic [WEW-1:0]          eff_w;
    logic [HEW-1:0]          eff_h;
    logic                    in_col_last, in_row_last;
    logic                    out_col_last, out_row_last;
    logic                    in_fire, is_pixel, flush_emit, pixel_emit;
    logic [PW-1:0]           pend_inc;
    logic [AW:0]             off_w, off_2w, off_p;

    // ring address base - off, wrapping at the ring depth
    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] base, input logic [AW:0] off);
        logic [AW:0] d;
        d = {1'b0, base} - off;
        if ({1'b0, base} < off)
        begin
            d = d + (AW+1)'(RING_DEPTH);
        end
        return d[AW-1:0];
    endfunction

    always_comb
    begin
        if (fw_reg == '0)
        begin
            eff_w = WEW'(1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            eff_w = WEW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WEW'(fw_reg);
        end

        if (fh_reg == '0)
        begin
            eff_h = HEW'(1);
        end
        else if (32'(fh_reg) > MAX_HEIGHT)
        begin
            eff_h = HEW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HEW'(fh_reg);
        end
    end

    assign in_col_last  = ((WEW+1)'(in_col_reg) + (WEW+1)'(1)) >= (WEW+1)'(eff_w);
    assign in_row_last  = ((HEW+1)'(in_row_reg) + (HEW+1)'(1)) >= (HEW+1)'(eff_h);
    assign out_col_last = ((WEW+1)'(out_col_reg) + (WEW+1)'(1)) >= (WEW+1)'(eff_w);
    assign out_row_last = ((HEW+1)'(out_row_reg) + (HEW+1)'(1)) >= (HEW+1)'(eff_h);

    assign in_ready   = !q_full;
    assign in_fire    = in_valid && in_ready;
    assign is_pixel   = (opcode_t'(in_opcode) == OP_PIXEL);
    assign pend_inc   = pend_reg + PW'(1);
    assign pixel_emit = (pend_inc >= (PW'(eff_w) + PW'(2)));
    // a flush only drains once the input side sits at the start of a frame
    assign flush_emit = (in_col_reg == '0) && (in_row_reg == '0) && (pend_reg != '0);

    assign off_w  = (AW+1)'(eff_w);
    assign off_2w = off_w << 1;
    assign off_p  = (AW+1)'(pend_reg);

    assign q_push          = in_fire && (is_pixel || flush_emit);
    assign q_cmd.is_pixel  = is_pixel;
    assign q_cmd.emit      = is_pixel ? pixel_emit : flush_emit;
    assign q_cmd.blur      = is_pixel && pixel_emit && (out_row_reg != '0) && (out_col_reg != '0)
                             && !out_row_last && !out_col_last;
    assign q_cmd.eof       = out_row_last && out_col_last;
    assign q_pix           = in_pix;
    assign q_wr_addr       = wp_reg;
    // pixel: row above and two rows above; flush: oldest pending word
    assign q_addr_a        = is_pixel ? ring_sub(wp_reg, off_w) : ring_sub(wp_reg, off_p);
    assign q_addr_b        = ring_sub(wp_reg, off_2w);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        wp_next      = wp_reg;
        pend_next    = pend_reg;

        if (in_fire && is_pixel)
        begin
            wp_next   = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            pend_next = pixel_emit ? pend_reg : pend_inc;
            if (in_col_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_last ? '0 : in_row_reg + ROWW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COLW'(1);
            end
        end
        else if (in_fire && flush_emit)
        begin
            pend_next = pend_reg - PW'(1);
        end

        if (in_fire && (is_pixel ? pixel_emit : flush_emit))
        begin
            if (out_col_last)
            begin
                out_col_next = '0;
                out_row_next = out_row_last ? '0 : out_row_reg + ROWW'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COLW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= FRAME_WIDTH_RST;
            fh_reg      <= FRAME_HEIGHT_RST;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            wp_reg      <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_FRAME_WIDTH:
                    begin
                        fw_reg <= cfg_wdata[WIDTH_REG_W-1:0];
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        fh_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                    end
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            wp_reg      <= wp_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

/* rtl/bblur_back.sv */
module bblur_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  bblur_pkg::blur_cmd_t        q_cmd,
    input  logic [bblur_pkg::PIX_W-1:0] q_pix,
    input  logic [AW-1:0]               q_wr_addr,
    input  logic [AW-1:0]               q_addr_a,
    input  logic [AW-1:0]               q_addr_b,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bblur_pkg::PIX_W-1:0] out_data,
    output logic                        out_last
);

    import bblur_pkg::*;

    localparam int RING_DEPTH = 2 * MAX_WIDTH + 1;
    localparam int CSUM_W     = CHAN_W + 2;
    localparam int WSUM_W     = CHAN_W + 4;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = WSUM_W + RECIP_W;
    localparam int RECIP_SH   = 16;
    // 7282 / 65536 floors to the same quotient as / 9 for sums up to 9 * 255
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

    logic [PIX_W-1:0]  ring [RING_DEPTH];
    logic [PIX_W-1:0]  rd_a_reg, rd_b_reg;

    logic              en;
    logic              a_valid_reg, b_valid_reg, c_valid_reg;
    blur_cmd_t         a_cmd_reg, b_cmd_reg, c_cmd_reg;
    logic [PIX_W-1:0]  a_pix_reg;
    logic [PIX_W-1:0]  b_flush_pix_reg;
    logic [PIX_W-1:0]  mid0_reg, mid1_reg;
    logic [NUM_CHAN-1:0][CSUM_W-1:0] cs0_reg, cs1_reg, cs2_reg, cs_new;
    logic [NUM_CHAN-1:0][WSUM_W-1:0] c_sum_reg;
    logic [PIX_W-1:0]  c_pass_reg;
    logic [PIX_W-1:0]  quot;
    logic [NUM_CHAN-1:0][PROD_W-1:0] prod;
    logic              out_valid_reg, out_last_reg;
    logic [PIX_W-1:0]  out_data_reg;

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && q_valid;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    // line ring: new pixel written, rows above read in the same cycle
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_cmd.is_pixel)
            begin
                ring[q_wr_addr] <= q_pix;
            end
            rd_a_reg <= ring[q_addr_a];
            rd_b_reg <= ring[q_addr_b];
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            cs_new[ch] = CSUM_W'(rd_b_reg[ch*CHAN_W +: CHAN_W])
                       + CSUM_W'(rd_a_reg[ch*CHAN_W +: CHAN_W])
                       + CSUM_W'(a_pix_reg[ch*CHAN_W +: CHAN_W]);
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            prod[ch] = PROD_W'(c_sum_reg[ch]) * PROD_W'(RECIP_9);
            quot[ch*CHAN_W +: CHAN_W] = prod[ch][RECIP_SH +: CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            a_cmd_reg     <= '0;
            b_cmd_reg     <= '0;
            c_cmd_reg     <= '0;
        end
        else if (en)
        begin
            a_valid_reg   <= q_pop;
            a_cmd_reg     <= q_cmd;
            b_valid_reg   <= a_valid_reg;
            b_cmd_reg     <= a_cmd_reg;
            c_valid_reg   <= b_valid_reg;
            c_cmd_reg     <= b_cmd_reg;
            out_valid_reg <= c_valid_reg && c_cmd_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pix_reg       <= q_pix;
            b_flush_pix_reg <= rd_a_reg;
            // window columns shift only on pixel words
            if (a_valid_reg && a_cmd_reg.is_pixel)
            begin
                mid1_reg <= mid0_reg;
                mid0_reg <= rd_a_reg;
                cs2_reg  <= cs1_reg;
                cs1_reg  <= cs0_reg;
                cs0_reg  <= cs_new;
            end
            c_pass_reg <= b_cmd_reg.is_pixel ? mid1_reg : b_flush_pix_reg;
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                c_sum_reg[ch] <= WSUM_W'(cs0_reg[ch]) + WSUM_W'(cs1_reg[ch])
                               + WSUM_W'(cs2_reg[ch]);
            end
            out_data_reg <= c_cmd_reg.blur ? quot : c_pass_reg;
            out_last_reg <= c_cmd_reg.eof;
        end
    end

endmodule

/* rtl/box_blur_3x3_rgb.sv */
// path: the releasing word runs through the queue, stages a, b, c and the output register;
// results trail the pixel stream by frame_width + 1 pixels, flush words drain the tail
// throughput: one word per cycle in and out (one-write two-read ring) while the sink is ready
// reset: positions, pending count and pipeline valids clear, registers return to
// 1024 x 768; the line ring is not cleared
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bblur_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bblur_pkg::PIX_W-1:0]         s_axis_tdata,  // in_red, in_green, in_blue
    input  logic [0:0]                          s_axis_tuser,  // opcode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bblur_pkg::PIX_W-1:0]         m_axis_tdata,  // out_red, out_green, out_blue
    output logic                                m_axis_tlast   // end_of_frame
);

    import bblur_pkg::*;

    localparam int RING_DEPTH = 2 * MAX_WIDTH + 1;
    localparam int AW         = $clog2(RING_DEPTH);
    localparam int ENTRY_W    = $bits(blur_cmd_t) + PIX_W + 3 * AW;

    logic             q_full, q_not_empty, q_push, q_pop;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;
    blur_cmd_t        f_cmd, b_cmd;
    logic [PIX_W-1:0] f_pix, b_pix;
    logic [AW-1:0]    f_wr, f_a, f_b, b_wr, b_a, b_b;

    bblur_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tuser),
        .in_pix    (s_axis_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (f_cmd),
        .q_pix     (f_pix),
        .q_wr_addr (f_wr),
        .q_addr_a  (f_a),
        .q_addr_b  (f_b)
    );

    assign q_wdata = {f_cmd, f_pix, f_wr, f_a, f_b};

    bblur_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    assign {b_cmd, b_pix, b_wr, b_a, b_b} = q_rdata;

    bblur_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_pop     (q_pop),
        .q_cmd     (b_cmd),
        .q_pix     (b_pix),
        .q_wr_addr (b_wr),
        .q_addr_a  (b_a),
        .q_addr_b  (b_b),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

/* tb/box_blur_3x3_rgb_tb.sv */
module box_blur_3x3_rgb_tb;

    import bblur_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 4096;
    localparam int RING_DEPTH    = 2 * MAX_W + 3;
    localparam int BLUR_DIV      = 9;
    localparam int RANDOM_PIXELS = 900;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct
    {
        opcode_t          op;
        logic [PIX_W-1:0] pix;
    } feed_word_t;

    typedef struct
    {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              eof;
    } blur_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata = '0;   // in_red, in_green, in_blue
    logic [0:0]            s_axis_tuser = '0;   // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;        // out_red, out_green, out_blue
    logic                  m_axis_tlast;        // end_of_frame

    feed_word_t feed_q[$];
    blur_out_t  blurred_q[$];
    int         mismatches = 0;
    int         cycle_count = 0;
    int         pixel_total = 0;

    // blur predictor state
    logic [PIX_W-1:0] ring [RING_DEPTH];
    int               ring_wr = 0;
    int               held_count = 0;
    logic [9:0]       in_col = '0;
    logic [11:0]      in_row = '0;
    logic [9:0]       out_col = '0;
    logic [11:0]      out_row = '0;
    int               eff_w = 1024;
    int               eff_h = 768;

    box_blur_3x3_rgb uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // a long stretch with no breaks in each period of the cycle count, otherwise about 15% idle
    function automatic bit take_break();
        if (cycle_count % 1600 >= 1000)
            return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    function automatic logic [PIX_W-1:0] looked_back(int back);
        return ring[(ring_wr + RING_DEPTH - 1 - (back % RING_DEPTH)) % RING_DEPTH];
    endfunction

    function automatic void release_oldest(bit may_blur);
        int               centre;
        int               top;
        int               sum_r;
        int               sum_g;
        int               sum_b;
        logic [PIX_W-1:0] nb;
        bit               on_border;
        bit               last_col;
        bit               last_row;
        blur_out_t        res;
        centre    = held_count - 1;
        last_col  = int'(out_col) + 1 >= eff_w;
        last_row  = int'(out_row) + 1 >= eff_h;
        on_border = out_row == 0 || out_col == 0 || last_row || last_col;
        if (!on_border && may_blur && centre >= eff_w + 1)
        begin
            // top-left neighbor is the oldest of the nine
            top   = centre + eff_w + 1;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int dr = 0; dr < 3; dr++)
            begin
                for (int dc = 0; dc < 3; dc++)
                begin
                    nb = looked_back(top - dr * eff_w - dc);
                    sum_r += nb[7:0];
                    sum_g += nb[15:8];
                    sum_b += nb[23:16];
                end
            end
            sum_r = sum_r / BLUR_DIV;
            sum_g = sum_g / BLUR_DIV;
            sum_b = sum_b / BLUR_DIV;
            res.red   = sum_r[7:0];
            res.green = sum_g[7:0];
            res.blue  = sum_b[7:0];
        end
        else
        begin
            nb = looked_back(centre);
            res.red   = nb[7:0];
            res.green = nb[15:8];
            res.blue  = nb[23:16];
        end
        res.eof = last_row && last_col;
        blurred_q.push_back(res);
        if (last_col)
        begin
            out_col = '0;
            out_row = last_row ? '0 : out_row + 1'b1;
        end
        else
            out_col = out_col + 1'b1;
        held_count--;
    endfunction

    function automatic void blur_take_word(opcode_t op, logic [PIX_W-1:0] pix);
        if (op == OP_FLUSH)
        begin
            // only drains at a frame boundary
            if (in_col == 0 && in_row == 0 && held_count > 0)
                release_oldest(1'b0);
            return;
        end
        ring[ring_wr] = pix;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        held_count++;
        if (int'(in_col) + 1 >= eff_w)
        begin
            in_col = '0;
            in_row = (int'(in_row) + 1 >= eff_h) ? '0 : in_row + 1'b1;
        end
        else
            in_col = in_col + 1'b1;
        if (held_count >= eff_w + 2)
            release_oldest(1'b1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive_in
        feed_word_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_PIXEL;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                blur_take_word(opcode_t'(s_axis_tuser[0]), s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (feed_q.size() != 0 && !take_break())
                begin
                    nxt = feed_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.pix;
                    s_axis_tuser  <= nxt.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_out
        blur_out_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (blurred_q.size() == 0)
                begin
                    $display("%0t: unexpected word expected none got %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = blurred_q.pop_front();
                    check_field("out_red", want.red, m_axis_tdata[7:0]);
                    check_field("out_green", want.green, m_axis_tdata[15:8]);
                    check_field("out_blue", want.blue, m_axis_tdata[23:16]);
                    check_field("end_of_frame", 8'(want.eof), 8'(m_axis_tlast));
                end
            end
            m_axis_tready <= !take_break();
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int value);
        int v;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
        begin
            v = value & 'h7FF;
            eff_w = (v < 1) ? 1 : (v > MAX_W) ? MAX_W : v;
        end
        else
        begin
            v = value & 'h1FFF;
            eff_h = (v < 1) ? 1 : (v > MAX_H) ? MAX_H : v;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (feed_q.size() != 0 || s_axis_tvalid || blurred_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pack_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return {b, g, r};
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        p = PIX_W'($urandom);
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if ($urandom_range(0, 9) == 0)
                p[c*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    function automatic void push_pixel(logic [PIX_W-1:0] pix);
        feed_q.push_back('{OP_PIXEL, pix});
        pixel_total++;
    endfunction

    function automatic void push_flushes(int n);
        for (int k = 0; k < n; k++)
            feed_q.push_back('{OP_FLUSH, rand_pixel()});
    endfunction

    // one whole frame at the current size, stray flushes only mid frame
    function automatic void queue_frame(int noise_pct);
        int n;
        n = eff_w * eff_h;
        for (int k = 0; k < n; k++)
        begin
            push_pixel(rand_pixel());
            if (k < n - 1 && $urandom_range(0, 99) < noise_pct)
                push_flushes(1);
        end
    endfunction

    initial
    begin : run
        int w_set;
        int h_set;
        int frames;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // 3x3: all-white frame, then a green and black frame with a magenta center, back to back
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        push_flushes(1);
        for (int k = 0; k < 9; k++)
        begin
            push_pixel(pack_rgb(8'hFF, 8'hFF, 8'hFF));
            if (k == 3)
                push_flushes(1);
        end
        for (int k = 0; k < 9; k++)
        begin
            if (k == 4)
                push_pixel(pack_rgb(8'hFF, 8'h00, 8'hFF));
            else if (k % 2 == 0)
                push_pixel(pack_rgb(8'h00, 8'hFF, 8'h00));
            else
                push_pixel(pack_rgb(8'h00, 8'h00, 8'h00));
        end
        push_flushes(5);
        wait_drained();

        pixel_total = 0;
        while (pixel_total < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 4) == 0)
                w_set = $urandom_range(13, 40);
            else
                w_set = $urandom_range(0, 12);
            h_set = $urandom_range(0, 9);
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_FRAME_HEIGHT, h_set);
                write_reg(REG_FRAME_WIDTH, w_set);
            end
            else
            begin
                write_reg(REG_FRAME_WIDTH, w_set);
                write_reg(REG_FRAME_HEIGHT, h_set);
            end
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                queue_frame(5);
                if (f < frames - 1)
                begin
                    case ($urandom_range(0, 2))
                        1: push_flushes($urandom_range(1, eff_w + 3));
                        2: push_flushes(1);
                        default: ;
                    endcase
                end
            end
            push_flushes(eff_w + 1 + $urandom_range(0, 2));
            wait_drained();
        end

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
